// ===== design/eitc_pkg.sv =====
// shared types, constants, checksum and field-slot helpers for the ethernet/ipv4/tcp header checker
package eitc_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int FRAME_LEN_BITS      = 16;
    localparam int L4_SLOTS            = 6;

    localparam int ETH_HDR_BYTES = 14;
    localparam int PSEUDO_FIRST  = 12;
    localparam int PSEUDO_LAST   = 19;
    localparam int ETYPE_HI_OFF  = 12;
    localparam int ETYPE_LO_OFF  = 13;
    localparam int IP_IHL_POS    = 0;
    localparam int IP_LEN_HI_POS = 2;
    localparam int IP_LEN_LO_POS = 3;
    localparam int IP_TTL_POS    = 8;
    localparam int IP_PROTO_POS  = 9;
    localparam int L4_HDR_BYTES  = 16;

    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

    localparam logic [7:0] IP_PROTO_TCP  = 8'd6;
    localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
    localparam logic [7:0] IP_PROTO_UDP  = 8'd17;

    localparam logic [1:0] EK_ARP   = 2'd0;
    localparam logic [1:0] EK_IPV4  = 2'd1;
    localparam logic [1:0] EK_IPV6  = 2'd2;
    localparam logic [1:0] EK_OTHER = 2'd3;

    localparam logic [1:0] PK_TCP   = 2'd0;
    localparam logic [1:0] PK_ICMP  = 2'd1;
    localparam logic [1:0] PK_UDP   = 2'd2;
    localparam logic [1:0] PK_OTHER = 2'd3;

    localparam int STATUS_IP_BIT  = 0;
    localparam int STATUS_TCP_BIT = 1;

    localparam logic [2:0] SLOT_SRC_PORT = 3'd0;
    localparam logic [2:0] SLOT_DST_PORT = 3'd1;
    localparam logic [2:0] SLOT_SEQ      = 3'd2;
    localparam logic [2:0] SLOT_ACK      = 3'd3;
    localparam logic [2:0] SLOT_FLAGS    = 3'd4;
    localparam logic [2:0] SLOT_WINDOW   = 3'd5;

    localparam logic [15:0] CKSUM_GOOD = 16'hFFFF;
    localparam logic [3:0]  IHL_MASK   = 4'hF;
    localparam logic [11:0] FLAGS_MASK = 12'h0FFF;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  eth_kind;
        logic [1:0]  proto_kind;
        logic [5:0]  ip_header_bytes;
        logic [15:0] ip_total_len;
        logic [7:0]  time_to_live;
        logic [1:0]  cksum_status;
        logic [15:0] source_port;
        logic [15:0] dst_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [11:0] tcp_flag_bits;
        logic [15:0] tcp_window;
    } result_t;

    // per-frame header state, also the header part of the snapshot handed to the summary stage
    typedef struct packed {
        logic [15:0]                     ethertype;
        logic [5:0]                      ihl_bytes;
        logic [15:0]                     total_len;
        logic [7:0]                      ttl;
        logic [7:0]                      protocol;
        logic [15:0]                     ip_sum;
        logic [15:0]                     tcp_sum;
        logic [L4_SLOTS-1:0][31:0]       l4_fields;
    } hdr_state_t;

    typedef struct packed {
        hdr_state_t              hdr;
        logic [FRAME_LEN_BITS-1:0] frame_len;
    } frame_snap_t;

    // ones' complement add with end-around carry
    function automatic logic [15:0] sum_add(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // which transport header field a segment byte belongs to
    function automatic logic [2:0] l4_slot(input logic [3:0] s);
        logic [2:0] k;
        if (s < 4'd2)       k = SLOT_SRC_PORT;
        else if (s < 4'd4)  k = SLOT_DST_PORT;
        else if (s < 4'd8)  k = SLOT_SEQ;
        else if (s < 4'd12) k = SLOT_ACK;
        else if (s < 4'd14) k = SLOT_FLAGS;
        else                k = SLOT_WINDOW;
        return k;
    endfunction

endpackage

// ===== design/eth_ipv4_tcp_header_checker.sv =====
// top level of the ethernet/ipv4/tcp header checker
//
// frames enter on the s_ channel one byte per transfer, starting at the destination mac,
// with last_byte set on the final byte. every byte is parsed in one pass: ethertype,
// ipv4 header fields and the ipv4 and tcp checksum sums are updated as it goes.
// the m_ channel carries one summary per frame, produced by the final byte only.
// throughput: one byte per cycle while s_ready is high, set by the per-byte update of the
// frame state registers; frames may follow each other with no gap.
// m_valid rises once the final byte has passed the input register and the frame snapshot
// into the result register; back-pressure from m_ready can hold it at each of these.
// reset (aresetn low, synchronous) empties all stages and clears the frame state, so
// the next byte taken is the first byte of a frame.
// when the receiver holds m_ready low, one summary waits in the result register and a
// second in the snapshot; non-final bytes keep flowing, and s_ready drops only when a
// final byte finds both of those full.
module eth_ipv4_tcp_header_checker #(
    parameter int OFFSET_BITS = eitc_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  eitc_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output eitc_pkg::result_t  m_data
);

    logic                  snap_valid;
    logic                  snap_ready;
    eitc_pkg::frame_snap_t snap_data;

    eitc_byte_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .snap_valid(snap_valid),
        .snap_ready(snap_ready),
        .snap_data (snap_data)
    );

    eitc_summary u_summary (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .snap_valid(snap_valid),
        .snap_ready(snap_ready),
        .snap_data (snap_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== design/eitc_byte_parser.sv =====
// input register, per-byte header parsing and checksum accumulation, frame snapshot register
module eitc_byte_parser #(
    parameter int OFFSET_BITS = eitc_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  eitc_pkg::in_item_t    s_data,
    output logic                  snap_valid,
    input  logic                  snap_ready,
    output eitc_pkg::frame_snap_t snap_data
);

    logic                   in_valid_reg;
    eitc_pkg::in_item_t     in_data_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [OFFSET_BITS-1:0] off_next;
    logic [7:0]             hold_reg;
    logic [7:0]             hold_next;
    eitc_pkg::hdr_state_t   st_reg;
    eitc_pkg::hdr_state_t   st_next;
    eitc_pkg::hdr_state_t   st_upd;
    logic                   snap_valid_reg;
    eitc_pkg::frame_snap_t  snap_data_reg;

    logic                   fire;
    logic                   snap_free;
    logic                   proc;
    logic [OFFSET_BITS-1:0] off_adv;
    logic [7:0]             b;
    logic                   odd;

    assign b         = in_data_reg.frame_byte;
    assign odd       = off_reg[0];
    assign proc      = (off_reg != {OFFSET_BITS{1'b1}});
    assign off_adv   = proc ? off_reg + OFFSET_BITS'(1) : off_reg;
    assign snap_free = !snap_valid_reg || snap_ready;
    assign fire      = in_valid_reg && (!in_data_reg.last_byte || snap_free);
    assign s_ready   = !in_valid_reg || fire;

    // header field capture and checksum update for the byte in the input register
    always_comb begin
        logic [OFFSET_BITS-1:0] pos;
        logic [15:0]            p16;
        logic                   in_ip;
        logic [5:0]             ihl_cur;
        logic [15:0]            tot_cur;
        logic [15:0]            word;
        logic [15:0]            s16;
        logic [15:0]            seg;
        logic                   in_seg;
        logic                   seg_hit;
        logic                   s_last;
        logic [15:0]            tcp1;
        logic [2:0]             k;

        st_upd  = st_reg;
        tcp1    = st_reg.tcp_sum;
        pos     = off_reg - OFFSET_BITS'(eitc_pkg::ETH_HDR_BYTES);
        p16     = 16'(pos);
        in_ip   = proc && (off_reg >= OFFSET_BITS'(eitc_pkg::ETH_HDR_BYTES));
        word    = {hold_reg, b};
        ihl_cur = (p16 == 16'(eitc_pkg::IP_IHL_POS))
                  ? {b[3:0] & eitc_pkg::IHL_MASK, 2'b00} : st_reg.ihl_bytes;
        tot_cur = (p16 == 16'(eitc_pkg::IP_LEN_HI_POS) || p16 == 16'(eitc_pkg::IP_LEN_LO_POS))
                  ? {st_reg.total_len[7:0], b} : st_reg.total_len;
        in_seg  = (p16 >= {10'd0, ihl_cur});
        s16     = p16 - {10'd0, ihl_cur};
        seg     = tot_cur - {10'd0, ihl_cur};
        seg_hit = in_seg && (s16 < seg);
        s_last  = ({1'b0, s16} + 17'd1) == {1'b0, seg};
        k       = eitc_pkg::l4_slot(s16[3:0]);

        if (proc && (off_reg == OFFSET_BITS'(eitc_pkg::ETYPE_HI_OFF)
                     || off_reg == OFFSET_BITS'(eitc_pkg::ETYPE_LO_OFF))) begin
            st_upd.ethertype = {st_reg.ethertype[7:0], b};
        end

        if (in_ip) begin
            st_upd.ihl_bytes = ihl_cur;
            st_upd.total_len = tot_cur;
            if (p16 == 16'(eitc_pkg::IP_TTL_POS)) begin
                st_upd.ttl = b;
            end
            if (p16 == 16'(eitc_pkg::IP_PROTO_POS)) begin
                st_upd.protocol = b;
            end
            if (!in_seg && odd) begin
                st_upd.ip_sum = eitc_pkg::sum_add(st_reg.ip_sum, word);
            end
            // address words of the pseudo header
            if (p16 >= 16'(eitc_pkg::PSEUDO_FIRST) && p16 <= 16'(eitc_pkg::PSEUDO_LAST) && odd) begin
                tcp1 = eitc_pkg::sum_add(st_reg.tcp_sum, word);
            end
            st_upd.tcp_sum = tcp1;
            if (seg_hit) begin
                if (odd) begin
                    st_upd.tcp_sum = eitc_pkg::sum_add(tcp1, word);
                end else if (s_last) begin
                    // odd-length segment, pad the final byte with zero
                    st_upd.tcp_sum = eitc_pkg::sum_add(tcp1, {b, 8'h00});
                end
            end
            if (in_seg && s16 < 16'(eitc_pkg::L4_HDR_BYTES)) begin
                for (int i = 0; i < eitc_pkg::L4_SLOTS; i++) begin
                    if (k == 3'(i)) begin
                        st_upd.l4_fields[i] = {st_reg.l4_fields[i][23:0], b};
                    end
                end
            end
        end
    end

    always_comb begin
        st_next   = st_reg;
        off_next  = off_reg;
        hold_next = hold_reg;
        if (fire) begin
            if (in_data_reg.last_byte) begin
                st_next   = '0;
                off_next  = '0;
                hold_next = '0;
            end else begin
                st_next  = st_upd;
                off_next = off_adv;
                if (proc && !odd) begin
                    hold_next = b;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            off_reg        <= '0;
            hold_reg       <= '0;
            st_reg         <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire && in_data_reg.last_byte) begin
                snap_valid_reg <= 1'b1;
            end else if (snap_ready) begin
                snap_valid_reg <= 1'b0;
            end
            off_reg  <= off_next;
            hold_reg <= hold_next;
            st_reg   <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (fire && in_data_reg.last_byte) begin
            snap_data_reg.hdr       <= st_upd;
            snap_data_reg.frame_len <= eitc_pkg::FRAME_LEN_BITS'(off_adv);
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_data  = snap_data_reg;

endmodule

// ===== design/eitc_summary.sv =====
// end-of-frame classification, checksum verdicts and result register
module eitc_summary (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  snap_valid,
    output logic                  snap_ready,
    input  eitc_pkg::frame_snap_t snap_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output eitc_pkg::result_t     m_data
);

    logic              m_valid_reg;
    eitc_pkg::result_t m_data_reg;
    eitc_pkg::result_t res_next;
    logic              take;

    assign snap_ready = !m_valid_reg || m_ready;
    assign take       = snap_valid && snap_ready;

    always_comb begin
        eitc_pkg::hdr_state_t h;
        logic [1:0]  ek;
        logic [1:0]  pk;
        logic [16:0] len17;
        logic [16:0] ip_end;
        logic [15:0] seg;
        logic [15:0] fin;
        logic [16:0] tcp_end;

        h       = snap_data.hdr;
        len17   = {1'b0, snap_data.frame_len};
        ip_end  = 17'(eitc_pkg::ETH_HDR_BYTES) + {11'd0, h.ihl_bytes};
        seg     = h.total_len - {10'd0, h.ihl_bytes};
        tcp_end = ip_end + {1'b0, seg};
        fin     = eitc_pkg::sum_add(eitc_pkg::sum_add(h.tcp_sum, {8'd0, h.protocol}), seg);

        priority if (h.ethertype == eitc_pkg::ETYPE_ARP)  ek = eitc_pkg::EK_ARP;
        else if (h.ethertype == eitc_pkg::ETYPE_IPV4)     ek = eitc_pkg::EK_IPV4;
        else if (h.ethertype == eitc_pkg::ETYPE_IPV6)     ek = eitc_pkg::EK_IPV6;
        else                                              ek = eitc_pkg::EK_OTHER;

        priority if (h.protocol == eitc_pkg::IP_PROTO_TCP) pk = eitc_pkg::PK_TCP;
        else if (h.protocol == eitc_pkg::IP_PROTO_ICMP)    pk = eitc_pkg::PK_ICMP;
        else if (h.protocol == eitc_pkg::IP_PROTO_UDP)     pk = eitc_pkg::PK_UDP;
        else                                               pk = eitc_pkg::PK_OTHER;

        res_next            = '0;
        res_next.eth_kind   = ek;
        res_next.proto_kind = eitc_pkg::PK_OTHER;
        if (ek == eitc_pkg::EK_IPV4) begin
            res_next.proto_kind      = pk;
            res_next.ip_header_bytes = h.ihl_bytes;
            res_next.ip_total_len    = h.total_len;
            res_next.time_to_live    = h.ttl;
            // truncated header reads as a bad checksum
            res_next.cksum_status[eitc_pkg::STATUS_IP_BIT] =
                (len17 >= ip_end) && (h.ip_sum == eitc_pkg::CKSUM_GOOD);
            if (pk == eitc_pkg::PK_TCP) begin
                res_next.cksum_status[eitc_pkg::STATUS_TCP_BIT] =
                    (h.total_len >= {10'd0, h.ihl_bytes}) && (len17 >= tcp_end)
                    && (fin == eitc_pkg::CKSUM_GOOD);
                res_next.source_port   = h.l4_fields[eitc_pkg::SLOT_SRC_PORT][15:0];
                res_next.dst_port      = h.l4_fields[eitc_pkg::SLOT_DST_PORT][15:0];
                res_next.seq_number    = h.l4_fields[eitc_pkg::SLOT_SEQ];
                res_next.ack_number    = h.l4_fields[eitc_pkg::SLOT_ACK];
                res_next.tcp_flag_bits = h.l4_fields[eitc_pkg::SLOT_FLAGS][11:0]
                                         & eitc_pkg::FLAGS_MASK;
                res_next.tcp_window    = h.l4_fields[eitc_pkg::SLOT_WINDOW][15:0];
            end else if (pk == eitc_pkg::PK_UDP) begin
                res_next.source_port = h.l4_fields[eitc_pkg::SLOT_SRC_PORT][15:0];
                res_next.dst_port    = h.l4_fields[eitc_pkg::SLOT_DST_PORT][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== bench/frame_summary_checker.sv =====
// scoreboard for the header checker: predicts each frame summary from the byte stream and compares
`timescale 1ns / 1ps
module frame_summary_checker #(
    parameter int OFFSET_BITS = eitc_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  eitc_pkg::in_item_t s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  eitc_pkg::result_t  m_data,
    output int                 fail_count,
    output int                 summaries_due
);

    localparam int OFF_LIMIT = (1 << OFFSET_BITS) - 1;

    int                frame_off;
    logic [15:0]       etype;
    logic [5:0]        ihl_bytes;
    logic [15:0]       total_len;
    logic [7:0]        ttl;
    logic [7:0]        proto;
    logic [15:0]       ip_sum;
    logic [15:0]       tcp_sum;
    logic [7:0]        even_byte;
    logic [31:0]       l4_words [eitc_pkg::L4_SLOTS];
    eitc_pkg::result_t summaries_expected [$];
    int                mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] t;
        t = acc + w;
        return t[15:0] + 16'(t[16]);
    endfunction

    task automatic clear_frame();
        frame_off = 0;
        etype     = '0;
        ihl_bytes = '0;
        total_len = '0;
        ttl       = '0;
        proto     = '0;
        ip_sum    = '0;
        tcp_sum   = '0;
        even_byte = '0;
        for (int i = 0; i < eitc_pkg::L4_SLOTS; i++) l4_words[i] = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int          p;
        int          s;
        logic [2:0]  k;
        logic [15:0] seg_len;
        logic [15:0] word;
        logic        odd;
        if (frame_off >= OFF_LIMIT) return;
        word = {even_byte, b};
        odd  = frame_off[0];
        if (frame_off == eitc_pkg::ETYPE_HI_OFF || frame_off == eitc_pkg::ETYPE_LO_OFF)
            etype = {etype[7:0], b};
        if (frame_off >= eitc_pkg::ETH_HDR_BYTES) begin
            p = frame_off - eitc_pkg::ETH_HDR_BYTES;
            if (p == eitc_pkg::IP_IHL_POS) ihl_bytes = {b[3:0], 2'b00};
            if (p == eitc_pkg::IP_LEN_HI_POS || p == eitc_pkg::IP_LEN_LO_POS)
                total_len = {total_len[7:0], b};
            if (p == eitc_pkg::IP_TTL_POS) ttl = b;
            if (p == eitc_pkg::IP_PROTO_POS) proto = b;
            if (p < int'(ihl_bytes) && odd) ip_sum = ones_add(ip_sum, word);
            if (p >= eitc_pkg::PSEUDO_FIRST && p <= eitc_pkg::PSEUDO_LAST && odd)
                tcp_sum = ones_add(tcp_sum, word);
            if (p >= int'(ihl_bytes)) begin
                s       = p - int'(ihl_bytes);
                seg_len = total_len - {10'd0, ihl_bytes};
                if (s < int'(seg_len)) begin
                    if (odd) tcp_sum = ones_add(tcp_sum, word);
                    // odd-length segment: last byte padded with zero
                    else if (s + 1 == int'(seg_len)) tcp_sum = ones_add(tcp_sum, {b, 8'h00});
                end
                if (s < eitc_pkg::L4_HDR_BYTES) begin
                    if (s < 2)       k = eitc_pkg::SLOT_SRC_PORT;
                    else if (s < 4)  k = eitc_pkg::SLOT_DST_PORT;
                    else if (s < 8)  k = eitc_pkg::SLOT_SEQ;
                    else if (s < 12) k = eitc_pkg::SLOT_ACK;
                    else if (s < 14) k = eitc_pkg::SLOT_FLAGS;
                    else             k = eitc_pkg::SLOT_WINDOW;
                    l4_words[k] = {l4_words[k][23:0], b};
                end
            end
        end
        if (!odd) even_byte = b;
        frame_off++;
    endtask

    function automatic eitc_pkg::result_t frame_summary();
        eitc_pkg::result_t r;
        int                seg;
        logic [15:0]       fin;
        r = '0;
        case (etype)
            eitc_pkg::ETYPE_ARP:  r.eth_kind = eitc_pkg::EK_ARP;
            eitc_pkg::ETYPE_IPV4: r.eth_kind = eitc_pkg::EK_IPV4;
            eitc_pkg::ETYPE_IPV6: r.eth_kind = eitc_pkg::EK_IPV6;
            default:              r.eth_kind = eitc_pkg::EK_OTHER;
        endcase
        r.proto_kind = eitc_pkg::PK_OTHER;
        if (r.eth_kind == eitc_pkg::EK_IPV4) begin
            case (proto)
                eitc_pkg::IP_PROTO_TCP:  r.proto_kind = eitc_pkg::PK_TCP;
                eitc_pkg::IP_PROTO_ICMP: r.proto_kind = eitc_pkg::PK_ICMP;
                eitc_pkg::IP_PROTO_UDP:  r.proto_kind = eitc_pkg::PK_UDP;
                default:                 r.proto_kind = eitc_pkg::PK_OTHER;
            endcase
            r.ip_header_bytes = ihl_bytes;
            r.ip_total_len    = total_len;
            r.time_to_live    = ttl;
            if (frame_off >= eitc_pkg::ETH_HDR_BYTES + int'(ihl_bytes)
                && ip_sum == eitc_pkg::CKSUM_GOOD)
                r.cksum_status[eitc_pkg::STATUS_IP_BIT] = 1'b1;
            if (r.proto_kind == eitc_pkg::PK_TCP) begin
                if (total_len >= {10'd0, ihl_bytes}) begin
                    seg = int'(total_len) - int'(ihl_bytes);
                    fin = ones_add(ones_add(tcp_sum, {8'h00, proto}), 16'(seg));
                    // a segment cut short by the end of the frame never passes
                    if (frame_off >= eitc_pkg::ETH_HDR_BYTES + int'(ihl_bytes) + seg
                        && fin == eitc_pkg::CKSUM_GOOD)
                        r.cksum_status[eitc_pkg::STATUS_TCP_BIT] = 1'b1;
                end
                r.source_port   = l4_words[eitc_pkg::SLOT_SRC_PORT][15:0];
                r.dst_port      = l4_words[eitc_pkg::SLOT_DST_PORT][15:0];
                r.seq_number    = l4_words[eitc_pkg::SLOT_SEQ];
                r.ack_number    = l4_words[eitc_pkg::SLOT_ACK];
                r.tcp_flag_bits = l4_words[eitc_pkg::SLOT_FLAGS][11:0] & eitc_pkg::FLAGS_MASK;
                r.tcp_window    = l4_words[eitc_pkg::SLOT_WINDOW][15:0];
            end else if (r.proto_kind == eitc_pkg::PK_UDP) begin
                r.source_port = l4_words[eitc_pkg::SLOT_SRC_PORT][15:0];
                r.dst_port    = l4_words[eitc_pkg::SLOT_DST_PORT][15:0];
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_summary(input eitc_pkg::result_t got);
        eitc_pkg::result_t want;
        if (summaries_expected.size() == 0) begin
            $display("%0t: summary with none pending, expected nothing, got %h", $time, got);
            mismatches++;
            return;
        end
        want = summaries_expected.pop_front();
        check_field("eth_kind", want.eth_kind, got.eth_kind);
        check_field("proto_kind", want.proto_kind, got.proto_kind);
        check_field("ip_header_bytes", want.ip_header_bytes, got.ip_header_bytes);
        check_field("ip_total_len", want.ip_total_len, got.ip_total_len);
        check_field("time_to_live", want.time_to_live, got.time_to_live);
        check_field("cksum_status", want.cksum_status, got.cksum_status);
        check_field("source_port", want.source_port, got.source_port);
        check_field("dst_port", want.dst_port, got.dst_port);
        check_field("seq_number", want.seq_number, got.seq_number);
        check_field("ack_number", want.ack_number, got.ack_number);
        check_field("tcp_flag_bits", want.tcp_flag_bits, got.tcp_flag_bits);
        check_field("tcp_window", want.tcp_window, got.tcp_window);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame();
            summaries_expected.delete();
        end else begin
            if (m_valid && m_ready) check_summary(m_data);
            if (s_valid && s_ready) begin
                absorb_byte(s_data.frame_byte);
                if (s_data.last_byte) begin
                    summaries_expected.push_back(frame_summary());
                    clear_frame();
                end
            end
        end
        summaries_due <= summaries_expected.size();
    end

endmodule

// ===== bench/eth_ipv4_tcp_header_checker_tb.sv =====
// testbench top for the header checker: builds frames, drives the byte channel, gives the verdict
`timescale 1ns / 1ps
module eth_ipv4_tcp_header_checker_tb;

    localparam int CYCLE_LIMIT = 20_000;

    localparam logic [15:0] ET_IPV4 = eitc_pkg::ETYPE_IPV4;
    localparam logic [15:0] ET_ARP  = eitc_pkg::ETYPE_ARP;
    localparam logic [15:0] ET_IPV6 = eitc_pkg::ETYPE_IPV6;
    localparam logic [7:0]  PR_TCP  = eitc_pkg::IP_PROTO_TCP;
    localparam logic [7:0]  PR_UDP  = eitc_pkg::IP_PROTO_UDP;
    localparam logic [7:0]  PR_ICMP = eitc_pkg::IP_PROTO_ICMP;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    eitc_pkg::in_item_t s_data;
    logic               m_valid;
    logic               m_ready;
    eitc_pkg::result_t  m_data;
    int                 fail_count;
    int                 summaries_due;
    int                 idle_pct = 31;
    int                 cycle_count = 0;
    int                 bytes_sent = 0;
    int                 frames_sent = 0;
    logic [7:0]         frame_bytes [$];

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    eth_ipv4_tcp_header_checker dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    frame_summary_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .summaries_due (summaries_due)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [15:0] add_end_around(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = a + b;
        return t[15:0] + 16'(t[16]);
    endfunction

    // ethernet header, ipv4-style header and segment, sums valid unless corrupted or too short
    task automatic make_frame(input logic [15:0] etype, input int ihl_words, input logic [7:0] proto,
                              input int seg_bytes, input int len_adj, input bit corrupt_ip,
                              input bit corrupt_l4, input int keep_bytes, input int pad);
        logic [7:0]  ip [$];
        logic [7:0]  seg [$];
        int          hdr_len;
        int          ip_len;
        logic [15:0] acc;
        logic [15:0] tot;
        frame_bytes.delete();
        for (int i = 0; i < 12; i++) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(etype[15:8]);
        frame_bytes.push_back(etype[7:0]);
        hdr_len = ihl_words * 4;
        ip_len  = (hdr_len < 20) ? 20 : hdr_len;
        tot     = 16'(hdr_len + seg_bytes + len_adj);
        for (int i = 0; i < ip_len; i++) ip.push_back(8'($urandom));
        ip[0] = {4'h4, 4'(ihl_words)};
        if ($urandom_range(15) == 0) ip[0][7:4] = 4'($urandom);
        ip[2]  = tot[15:8];
        ip[3]  = tot[7:0];
        ip[9]  = proto;
        ip[10] = 8'h00;
        ip[11] = 8'h00;
        if (hdr_len >= 20) begin
            acc = '0;
            for (int i = 0; i < hdr_len; i += 2) acc = add_end_around(acc, {ip[i], ip[i+1]});
            ip[10] = ~acc[15:8];
            ip[11] = ~acc[7:0];
        end
        for (int i = 0; i < seg_bytes; i++) seg.push_back(8'($urandom));
        if (proto == PR_TCP && seg_bytes >= 18 && hdr_len >= 20) begin
            seg[16] = 8'h00;
            seg[17] = 8'h00;
            acc = '0;
            for (int i = 12; i < 20; i += 2) acc = add_end_around(acc, {ip[i], ip[i+1]});
            acc = add_end_around(acc, {8'h00, proto});
            acc = add_end_around(acc, 16'(seg_bytes));
            for (int i = 0; i < seg_bytes; i += 2)
                acc = add_end_around(acc, {seg[i], (i + 1 < seg_bytes) ? seg[i+1] : 8'h00});
            seg[16] = ~acc[15:8];
            seg[17] = ~acc[7:0];
        end
        if (corrupt_ip) ip[10] = ip[10] ^ 8'(1 << $urandom_range(7));
        if (corrupt_l4 && seg_bytes >= 18) seg[16] = seg[16] ^ 8'(1 << $urandom_range(7));
        foreach (ip[i]) frame_bytes.push_back(ip[i]);
        foreach (seg[i]) frame_bytes.push_back(seg[i]);
        for (int i = 0; i < pad; i++) frame_bytes.push_back(8'($urandom));
        if (keep_bytes > 0)
            while (frame_bytes.size() > keep_bytes) void'(frame_bytes.pop_back());
    endtask

    task automatic send_frame();
        eitc_pkg::in_item_t item;
        // a run of frames with no idling on either side
        idle_pct = (frames_sent >= 8 && frames_sent < 16) ? 0 : 31;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            item.frame_byte = frame_bytes[i];
            item.last_byte  = (i == frame_bytes.size() - 1);
            while ($urandom_range(99) < idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= item;
            do @(posedge aclk); while (!s_ready);
        end
        bytes_sent += frame_bytes.size();
        frames_sent++;
    endtask

    // mostly ipv4 frames, tcp the most common protocol, with odd headers, bad sums, cut and padded frames
    task automatic random_frame();
        int          pick;
        int          ihl_w;
        int          seg_n;
        int          adj;
        int          keep;
        int          pad;
        logic [15:0] et;
        logic [7:0]  pr;
        pick = $urandom_range(99);
        if (pick < 80)      et = ET_IPV4;
        else if (pick < 86) et = ET_ARP;
        else if (pick < 92) et = ET_IPV6;
        else                et = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)      ihl_w = 5;
        else if (pick < 90) ihl_w = $urandom_range(15, 6);
        else                ihl_w = $urandom_range(4, 0);
        pick = $urandom_range(99);
        if (pick < 60)      pr = PR_TCP;
        else if (pick < 75) pr = PR_UDP;
        else if (pick < 85) pr = PR_ICMP;
        else                pr = 8'($urandom);
        seg_n = (pr == PR_TCP) ? $urandom_range(28, 18) : $urandom_range(16, 0);
        pick = $urandom_range(99);
        if (pick < 85)      adj = 0;
        else if (pick < 93) adj = int'($urandom_range(30)) - 15;
        else                adj = int'($urandom_range(65535));
        keep = ($urandom_range(99) < 10) ? $urandom_range(14 + ihl_w * 4 + seg_n, 1) : 0;
        pad  = ($urandom_range(99) < 15) ? $urandom_range(10, 1) : 0;
        make_frame(et, ihl_w, pr, seg_n, adj, $urandom_range(9) == 0, $urandom_range(9) == 0,
                   keep, pad);
        send_frame();
    endtask

    initial begin
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // frames of one byte and of a cut ethertype, then each ethertype kind
        make_frame(ET_IPV4, 5, PR_TCP, 20, 0, 0, 0, 1, 0);   send_frame();
        make_frame(ET_IPV4, 5, PR_TCP, 20, 0, 0, 0, 13, 0);  send_frame();
        make_frame(ET_ARP, 5, PR_TCP, 8, 0, 0, 0, 0, 0);     send_frame();
        make_frame(ET_IPV6, 5, PR_TCP, 20, 0, 0, 0, 0, 0);   send_frame();
        make_frame(16'hFFFF, 5, PR_UDP, 4, 0, 0, 0, 0, 0);   send_frame();
        make_frame(16'h0000, 5, PR_UDP, 4, 0, 0, 0, 0, 0);   send_frame();
        make_frame(ET_IPV4, 5, PR_TCP, 20, 0, 0, 0, 0, 0);   send_frame();
        // odd segment length plus link padding, then bad sums, other protocols and the longest header
        make_frame(ET_IPV4, 5, PR_TCP, 21, 0, 0, 0, 0, 6);   send_frame();
        make_frame(ET_IPV4, 5, PR_TCP, 24, 0, 1, 0, 0, 0);   send_frame();
        make_frame(ET_IPV4, 5, PR_TCP, 24, 0, 0, 1, 0, 0);   send_frame();
        make_frame(ET_IPV4, 5, PR_UDP, 12, 0, 0, 0, 0, 0);   send_frame();
        make_frame(ET_IPV4, 5, PR_ICMP, 8, 0, 0, 0, 0, 0);   send_frame();
        make_frame(ET_IPV4, 5, 8'hFF, 4, 0, 0, 0, 0, 0);     send_frame();
        make_frame(ET_IPV4, 5, 8'h00, 0, 0, 0, 0, 0, 0);     send_frame();
        make_frame(ET_IPV4, 15, PR_TCP, 25, 0, 0, 0, 0, 0);  send_frame();
        // short header lengths, including an empty header sum
        make_frame(ET_IPV4, 0, PR_TCP, 20, 0, 0, 0, 0, 0);   send_frame();
        make_frame(ET_IPV4, 4, PR_TCP, 20, 0, 0, 0, 0, 0);   send_frame();
        make_frame(ET_IPV4, 1, PR_UDP, 8, 0, 0, 0, 0, 0);    send_frame();
        // truncated in the ip header, then in the tcp segment
        make_frame(ET_IPV4, 5, PR_TCP, 20, 0, 0, 0, 24, 0);  send_frame();
        make_frame(ET_IPV4, 5, PR_TCP, 20, 0, 0, 0, 44, 0);  send_frame();
        // total length below header length, then far beyond the frame
        make_frame(ET_IPV4, 5, PR_TCP, 20, -30, 0, 0, 0, 0); send_frame();
        make_frame(ET_IPV4, 5, PR_TCP, 20, 5000, 0, 0, 0, 0); send_frame();

        while (bytes_sent < 1300) begin
            random_frame();
        end
        idle_pct = 31;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (summaries_due != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/eitc_pkg.sv
design/eitc_byte_parser.sv
design/eitc_summary.sv
design/eth_ipv4_tcp_header_checker.sv
bench/frame_summary_checker.sv
bench/eth_ipv4_tcp_header_checker_tb.sv
